>>> sv/rd_pkg.sv
// Shared types and constants for the restoring divider.
// Holds the request and response item structs and the cell control struct.
// No dependencies.
`default_nettype none

package rd_pkg;

    // Width of every field of the request and response items.
    localparam int FIELD_W = 16;

    // One request item: the operands.
    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } req_t;

    // One response item: the results.
    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
    } rsp_t;

    // Control that the sequencer broadcasts along the row of cells.
    typedef struct packed {
        logic load;
        logic step;
    } rd_ctrl_t;

endpackage

`default_nettype wire

>>> sv/rd_cell.sv
// One bit slice of the divider: a remainder bit, a quotient bit and a divisor bit.
// Contains one full subtractor stage of the borrow chain. Uses rd_pkg.
`default_nettype none

module rd_cell (
    input  wire logic             clk,
    input  wire rd_pkg::rd_ctrl_t ctrl,
    input  wire logic             dvd_bit,
    input  wire logic             dvs_bit,
    input  wire logic             a_shift_in,
    input  wire logic             q_shift_in,
    input  wire logic             borrow_in,
    input  wire logic             keep_diff,
    output logic                  a_bit,
    output logic                  q_bit,
    output logic                  borrow_out,
    output logic                  a_next_bit,
    output logic                  q_next_bit
);
    import rd_pkg::*;

    logic a_reg;
    logic q_reg;
    logic m_reg;
    logic a_next;
    logic q_next;
    logic m_next;
    logic diff;

    // Subtract the divisor bit from the shifted remainder bit.
    always_comb
    begin
        diff       = a_shift_in ^ m_reg ^ borrow_in;
        borrow_out = (~a_shift_in & m_reg) | (~(a_shift_in ^ m_reg) & borrow_in);
    end

    // The shifted bits either keep the difference or restore the remainder.
    always_comb
    begin
        a_next_bit = keep_diff ? diff : a_shift_in;
        q_next_bit = q_shift_in;
        a_next     = a_reg;
        q_next     = q_reg;
        m_next     = m_reg;
        if (ctrl.load)
        begin
            a_next = 1'b0;
            q_next = dvd_bit;
            m_next = dvs_bit;
        end
        else if (ctrl.step)
        begin
            a_next = a_next_bit;
            q_next = q_next_bit;
        end
    end

    // Payload bits carry no reset.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        q_reg <= q_next;
        m_reg <= m_next;
    end

    assign a_bit = a_reg;
    assign q_bit = q_reg;

endmodule

`default_nettype wire

>>> sv/rd_chain.sv
// Row of WIDTH divider cells linked by the shift paths and the borrow chain.
// Decides the quotient bit from the top borrow. Uses rd_pkg and rd_cell.
`default_nettype none

module rd_chain #(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire rd_pkg::rd_ctrl_t ctrl,
    input  wire logic [WIDTH-1:0] dvd,
    input  wire logic [WIDTH-1:0] dvs,
    output logic      [WIDTH-1:0] q_next,
    output logic      [WIDTH-1:0] a_next
);
    import rd_pkg::*;

    logic [WIDTH-1:0] a_bits;
    logic [WIDTH-1:0] q_bits;
    logic [WIDTH:0]   borrow;
    logic [WIDTH-1:0] a_shift;
    logic [WIDTH-1:0] q_shift;
    logic             keep_diff;

    // Remainder and quotient shift left together; the top quotient bit
    // enters the remainder and the new quotient bit enters at the bottom.
    assign a_shift = {a_bits[WIDTH-2:0], q_bits[WIDTH-1]};
    assign q_shift = {q_bits[WIDTH-2:0], keep_diff};

    // The difference is non-negative when the bit shifted out of the
    // remainder was set or the subtraction left no borrow.
    assign borrow[0] = 1'b0;
    assign keep_diff = a_bits[WIDTH-1] | ~borrow[WIDTH];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        rd_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .dvd_bit    (dvd[i]),
            .dvs_bit    (dvs[i]),
            .a_shift_in (a_shift[i]),
            .q_shift_in (q_shift[i]),
            .borrow_in  (borrow[i]),
            .keep_diff  (keep_diff),
            .a_bit      (a_bits[i]),
            .q_bit      (q_bits[i]),
            .borrow_out (borrow[i+1]),
            .a_next_bit (a_next[i]),
            .q_next_bit (q_next[i])
        );
    end

endmodule

`default_nettype wire

>>> sv/restoring_divider.sv
// An accepted item is loaded into the single row of cells, which iterates once
// per quotient bit, one shift-subtract per iteration; the last iteration writes
// the output register and waits while a stalled result still holds it. No new
// item is taken until the run ends, but one is taken while a result waits.
// Reset clears the sequencer and the output valid flag; operand and result
// registers are not reset.
// Top level of the unsigned restoring divider. Uses rd_pkg and rd_chain.
`default_nettype none

module restoring_divider #(
    parameter int WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire rd_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output rd_pkg::rsp_t      rsp
);
    import rd_pkg::*;

    localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    rd_ctrl_t         ctrl;
    logic             accept;
    logic             last;
    logic             rsp_free;
    logic             finish;
    logic [WIDTH-1:0] dvd;
    logic [WIDTH-1:0] dvs;
    logic [WIDTH-1:0] q_next;
    logic [WIDTH-1:0] a_next;
    logic [FIELD_W-1:0] quo_field;
    logic [FIELD_W-1:0] rem_field;

    // Fit the operand fields to the operand width, and the results back.
    if (WIDTH > FIELD_W)
    begin : g_wide
        assign dvd       = {{(WIDTH-FIELD_W){1'b0}}, req.dividend};
        assign dvs       = {{(WIDTH-FIELD_W){1'b0}}, req.divisor};
        assign quo_field = q_next[FIELD_W-1:0];
        assign rem_field = a_next[FIELD_W-1:0];
    end
    else if (WIDTH == FIELD_W)
    begin : g_same
        assign dvd       = req.dividend;
        assign dvs       = req.divisor;
        assign quo_field = q_next;
        assign rem_field = a_next;
    end
    else
    begin : g_narrow
        assign dvd       = req.dividend[WIDTH-1:0];
        assign dvs       = req.divisor[WIDTH-1:0];
        assign quo_field = {{(FIELD_W-WIDTH){1'b0}}, q_next};
        assign rem_field = {{(FIELD_W-WIDTH){1'b0}}, a_next};
    end

    // Handshake and iteration control.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid & ~req_stall;
    assign last      = (cnt_reg == CNT_LAST);
    assign rsp_free  = ~rsp_valid_reg | ~rsp_stall;
    assign finish    = (state_reg == ST_BUSY) & last & rsp_free;

    // The last iteration waits until the output register can take its item.
    assign ctrl = '{load: accept,
                    step: (state_reg == ST_BUSY) & (~last | rsp_free)};

    rd_chain #(
        .WIDTH (WIDTH)
    ) u_chain (
        .clk    (clk),
        .ctrl   (ctrl),
        .dvd    (dvd),
        .dvs    (dvs),
        .q_next (q_next),
        .a_next (a_next)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                    cnt_next   = '0;
                end
            end
            ST_BUSY:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else if (ctrl.step)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Output register: loaded on the final iteration, held while stalled.
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        if (finish)
        begin
            rsp_next.quotient  = quo_field;
            rsp_next.remainder = rem_field;
            rsp_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted item always starts an iteration run.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_BUSY) && (cnt_reg == '0))
        else $error("accepted item did not start the divider");

    // A new result appears only after the final iteration.
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_BUSY && cnt_reg == CNT_LAST))
        else $error("result written before the final iteration");

    // The iteration counter rests at zero between items.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("iteration counter not cleared when idle");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !finish)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire
